/* hdl/sgm_pkg.sv */
// Package for the Sobel gradient magnitude/direction core.
// Types and constants shared by the front end, back end and top level.
package sgm_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned MagW    = 11;
  localparam int unsigned DirW    = 2;
  localparam int unsigned PosW    = 11;
  localparam int unsigned ChW     = 2;
  localparam int unsigned CfgW    = 12;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned RowLimit = 2048;

  // Line store geometry: widest row and most interleaved channels
  localparam int unsigned MaxColumns  = 2048;
  localparam int unsigned MaxChannels = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgColumns  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRows     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgChannels = 2'd2;

  // Q16 tangents of 22.5 and 67.5 degrees
  localparam logic [17:0] TanLowQ16  = 18'd27146;
  localparam logic [17:0] TanHighQ16 = 18'd158218;

  // Direction codes
  localparam logic [DirW-1:0] Dir0   = 2'd0;
  localparam logic [DirW-1:0] Dir45  = 2'd1;
  localparam logic [DirW-1:0] Dir90  = 2'd2;
  localparam logic [DirW-1:0] Dir135 = 2'd3;

  // One gradient job: nine window taps already placed, plus position
  typedef struct packed {
    logic [8:0][SampleW-1:0] taps;  // [row*3+col], row 0 top, col 0 left
    logic [PosW-1:0]         row;
    logic [PosW-1:0]         col;
    logic [ChW-1:0]          ch;
    logic                    last;
  } sgm_job_t;

  typedef struct packed {
    logic [MagW-1:0] magnitude;
    logic [DirW-1:0] direction;
    logic [PosW-1:0] out_row;
    logic [PosW-1:0] out_column;
    logic [ChW-1:0]  out_channel;
    logic            last_of_run;
  } sgm_result_t;

  // Back-end state machine
  typedef enum logic [1:0] {
    BeIdle,
    BeSqrt,
    BeDir,
    BeOut
  } sgm_be_state_e;

endpackage

/* hdl/sgm_stream_if.sv */
// Valid/ready stream interface with a parameterized payload type.
// Depends on nothing; used for the input and result channels.
interface sgm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/sgm_front.sv */
// Front end: position counters, line stores, per-channel windows, job issue.
// Depends on sgm_pkg. Emits up to four gradient jobs per accepted sample.
module sgm_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [sgm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sgm_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [sgm_pkg::SampleW-1:0] in_sample_i,
  output logic                    job_valid_o,
  input  logic                    job_ready_i,
  output sgm_pkg::sgm_job_t       job_o
);
  import sgm_pkg::*;

  localparam int unsigned Depth = MaxColumns * MaxChannels;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned ChCntW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int unsigned ColCntW = $clog2(MaxColumns + 1);

  // Configuration registers
  logic [CfgW-1:0] cols_raw_q, rows_raw_q;
  logic [2:0]      chs_raw_q;
  logic [ColCntW-1:0] cols;
  logic [11:0]     rows;
  logic [3:0]      chs;

  always_comb begin
    if (cols_raw_q < 12'd2) cols = ColCntW'(2);
    else if ({20'd0, cols_raw_q} > 32'(MaxColumns)) cols = ColCntW'(MaxColumns);
    else cols = ColCntW'(cols_raw_q);
    if (rows_raw_q < 12'd2) rows = 12'd2;
    else if ({20'd0, rows_raw_q} > 32'(RowLimit)) rows = 12'(RowLimit);
    else rows = rows_raw_q;
    if (chs_raw_q < 3'd1) chs = 4'd1;
    else if ({29'd0, chs_raw_q} > 32'(MaxChannels)) chs = 4'(MaxChannels);
    else chs = {1'b0, chs_raw_q};
  end

  // Position counters
  logic [PosW-1:0] row_q, col_q;
  logic [ChCntW-1:0] ch_q;
  logic [AddrW-1:0] addr_q;   // col*chs + ch

  // Stage-1 capture: sample and position while the stores are read
  logic             s1_valid_q;
  logic [SampleW-1:0] s1_sample_q;
  logic [PosW-1:0]  s1_row_q, s1_col_q;
  logic [ChCntW-1:0] s1_ch_q;
  logic             s1_lrow_q, s1_lcol_q;

  // Window regs per channel: [col 0 oldest..2][row 0..2]
  logic [MaxChannels-1:0][2:0][2:0][SampleW-1:0] win_q;

  // Pending emissions of the window being worked on
  logic [3:0]        pend_q;
  logic [2:0][2:0][SampleW-1:0] cur_q;
  logic [PosW-1:0]   cur_row_q, cur_col_q;
  logic [ChW-1:0]    cur_ch_q;

  logic accept, busy;
  assign busy       = s1_valid_q || (pend_q != 4'd0);
  assign in_ready_o = !busy;
  assign accept     = in_valid_i && in_ready_o;

  // Line stores
  logic [SampleW-1:0] up_mem [Depth];
  logic [SampleW-1:0] lo_mem [Depth];
  logic [SampleW-1:0] up_rd_q, lo_rd_q;
  logic [AddrW-1:0]   s1_addr_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_rd_q <= up_mem[addr_q];
      lo_rd_q <= lo_mem[addr_q];
    end
    if (s1_valid_q) begin
      up_mem[s1_addr_q] <= lo_rd_q;
      lo_mem[s1_addr_q] <= s1_sample_q;
    end
  end

  // Counter advance
  logic lcol, lrow, lch;
  assign lch  = ({{(4-ChCntW){1'b0}}, ch_q} + 4'd1) >= chs;
  assign lcol = (ColCntW'(col_q) == (cols - ColCntW'(1)));
  assign lrow = ({1'b0, row_q} == (rows - 12'd1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_raw_q <= 12'd640;
      rows_raw_q <= 12'd480;
      chs_raw_q  <= 3'd1;
      row_q <= '0;
      col_q <= '0;
      ch_q  <= '0;
      addr_q <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgColumns:  cols_raw_q <= cfg_data_i;
          CfgRows:     rows_raw_q <= cfg_data_i;
          CfgChannels: chs_raw_q  <= cfg_data_i[2:0];
          default: ;
        endcase
        if (cfg_idx_i == CfgColumns || cfg_idx_i == CfgRows ||
            cfg_idx_i == CfgChannels) begin
          row_q <= '0;
          col_q <= '0;
          ch_q  <= '0;
          addr_q <= '0;
        end
      end else if (accept) begin
        if (lch) begin
          ch_q <= '0;
          if (lcol) begin
            col_q <= '0;
            addr_q <= '0;
            row_q <= lrow ? '0 : row_q + PosW'(1);
          end else begin
            col_q <= col_q + PosW'(1);
            addr_q <= addr_q + AddrW'(1);
          end
        end else begin
          ch_q <= ch_q + ChCntW'(1);
          addr_q <= addr_q + AddrW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= in_sample_i;
      s1_row_q    <= row_q;
      s1_col_q    <= col_q;
      s1_ch_q     <= ch_q;
      s1_lrow_q   <= lrow;
      s1_lcol_q   <= lcol;
      s1_addr_q   <= addr_q;
    end
  end

  // Window shift and emission bookkeeping
  logic [2:0][2:0][SampleW-1:0] nw;
  always_comb begin
    nw = win_q[s1_ch_q];
    nw[0] = nw[1];
    nw[1] = nw[2];
    nw[2][0] = up_rd_q;
    nw[2][1] = lo_rd_q;
    nw[2][2] = s1_sample_q;
  end

  logic [3:0] pend_new;
  assign pend_new = {s1_lrow_q && s1_lcol_q,
                     s1_lrow_q && (s1_col_q != '0),
                     (s1_row_q != '0) && s1_lcol_q,
                     (s1_row_q != '0) && (s1_col_q != '0)};

  logic [1:0] sel;
  always_comb begin
    priority if (pend_q[0]) sel = 2'd0;
    else if (pend_q[1])     sel = 2'd1;
    else if (pend_q[2])     sel = 2'd2;
    else                    sel = 2'd3;
  end

  logic [3:0] pend_after;
  always_comb begin
    pend_after = pend_q;
    pend_after[sel] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      pend_q <= '0;
    end else if (s1_valid_q) begin
      win_q[s1_ch_q] <= nw;
      pend_q <= pend_new;
    end else if (job_valid_o && job_ready_i) begin
      pend_q <= pend_after;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      cur_q     <= nw;
      cur_row_q <= s1_row_q;
      cur_col_q <= s1_col_q;
      cur_ch_q  <= ChW'(s1_ch_q);
    end
  end

  // Tap selection for the chosen emission
  logic [1:0] lc, cc, rc, tr, mr, br;
  always_comb begin
    lc = (cur_col_q == PosW'(1)) ? 2'd2 : 2'd0; cc = 2'd1; rc = 2'd2;
    tr = (cur_row_q == PosW'(1)) ? 2'd2 : 2'd0; mr = 2'd1; br = 2'd2;
    job_o.row = cur_row_q - PosW'(1);
    job_o.col = cur_col_q - PosW'(1);
    unique case (sel)
      2'd0: ;
      2'd1: begin
        lc = 2'd1; cc = 2'd2; rc = 2'd1;
        job_o.col = cur_col_q;
      end
      2'd2: begin
        tr = 2'd1; mr = 2'd2; br = 2'd1;
        job_o.row = cur_row_q;
      end
      default: begin
        lc = 2'd1; cc = 2'd2; rc = 2'd1;
        tr = 2'd1; mr = 2'd2; br = 2'd1;
        job_o.row = cur_row_q;
        job_o.col = cur_col_q;
      end
    endcase
    job_o.taps[0] = cur_q[lc][tr];
    job_o.taps[1] = cur_q[cc][tr];
    job_o.taps[2] = cur_q[rc][tr];
    job_o.taps[3] = cur_q[lc][mr];
    job_o.taps[4] = cur_q[cc][mr];
    job_o.taps[5] = cur_q[rc][mr];
    job_o.taps[6] = cur_q[lc][br];
    job_o.taps[7] = cur_q[cc][br];
    job_o.taps[8] = cur_q[rc][br];
    job_o.ch   = cur_ch_q;
    job_o.last = (pend_after == 4'd0);
  end

  assign job_valid_o = !s1_valid_q && (pend_q != 4'd0);

endmodule

/* hdl/sgm_queue.sv */
// Short job queue between front end and back end.
// Depends on sgm_pkg for the job type.
module sgm_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  sgm_pkg::sgm_job_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output sgm_pkg::sgm_job_t rd_data_o
);
  import sgm_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);

  sgm_job_t        buf_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            wr, rd;

  assign wr_ready_o = cnt_q != (PtrW+1)'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) buf_q[wp_q] <= wr_data_i;
  end

  // Pointers wrap at Depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == PtrW'(Depth-1)) ? '0 : wp_q + PtrW'(1);
      if (rd) rp_q <= (rp_q == PtrW'(Depth-1)) ? '0 : rp_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

endmodule

/* hdl/sgm_back.sv */
// Back end: Sobel sums, iterative square root, direction test, result register.
// Depends on sgm_pkg.
module sgm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  output logic                  job_ready_o,
  input  sgm_pkg::sgm_job_t     job_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output sgm_pkg::sgm_result_t  res_o
);
  import sgm_pkg::*;

  sgm_be_state_e state_q, state_d;

  logic signed [10:0] gx_q, gy_q;
  logic [20:0] rem_q;       // radicand remainder
  logic [10:0] root_q;
  logic [3:0]  step_q;      // 11 root bits, one per cycle
  logic [PosW-1:0] row_q, col_q;
  logic [ChW-1:0]  ch_q;
  logic            last_q;
  logic [35:0] ay_q, lo_q, hi_q;
  logic        neg_q, gy0_q, gx0_q;
  sgm_result_t out_q;
  logic        out_valid_q;

  // Sobel sums from the selected taps
  logic signed [10:0] gx, gy;
  always_comb begin
    gx = 11'(signed'({3'b0, job_i.taps[2]})) - 11'(signed'({3'b0, job_i.taps[0]}))
       + 11'(signed'({2'b0, job_i.taps[5], 1'b0})) - 11'(signed'({2'b0, job_i.taps[3], 1'b0}))
       + 11'(signed'({3'b0, job_i.taps[8]})) - 11'(signed'({3'b0, job_i.taps[6]}));
    gy = 11'(signed'({3'b0, job_i.taps[0]})) + 11'(signed'({2'b0, job_i.taps[1], 1'b0}))
       + 11'(signed'({3'b0, job_i.taps[2]})) - 11'(signed'({3'b0, job_i.taps[6]}))
       - 11'(signed'({2'b0, job_i.taps[7], 1'b0})) - 11'(signed'({3'b0, job_i.taps[8]}));
  end

  // Sum of squares; the radicand is registered for the root loop
  logic signed [21:0] gx2, gy2;
  logic [20:0] sq;
  assign gx2 = 22'(gx) * 22'(gx);
  assign gy2 = 22'(gy) * 22'(gy);
  assign sq  = 21'(gx2 + gy2);

  // One root bit per cycle (restoring)
  logic [10:0] trial;
  logic [21:0] tsq;
  assign trial = root_q | (11'd1 << step_q);
  assign tsq   = 22'(trial) * 22'(trial);

  // Folded direction operands
  logic signed [10:0] fx, fy;
  logic [10:0] ax;
  assign fx = gy_q[10] ? -gx_q : gx_q;
  assign fy = gy_q[10] ? -gy_q : gy_q;
  assign ax = fx[10] ? 11'(-fx) : 11'(fx);

  logic [1:0] dir;
  always_comb begin
    priority if (gy0_q)    dir = Dir0;
    else if (gx0_q)        dir = Dir90;
    else if (!neg_q) begin
      if (ay_q < lo_q)      dir = Dir0;
      else if (ay_q < hi_q) dir = Dir45;
      else                  dir = Dir90;
    end else begin
      if (ay_q <= lo_q)      dir = Dir0;
      else if (ay_q <= hi_q) dir = Dir135;
      else                   dir = Dir90;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BeIdle: if (job_valid_i) state_d = BeSqrt;
      BeSqrt: if (step_q == 4'd0) state_d = BeDir;
      BeDir:  state_d = BeOut;
      BeOut:  if (!out_valid_q || res_ready_i) state_d = BeIdle;
      default: state_d = BeIdle;
    endcase
  end

  // Outputs
  always_comb begin
    job_ready_o = (state_q == BeIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BeIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BeOut && (!out_valid_q || res_ready_i)) out_valid_q <= 1'b1;
      else if (res_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BeIdle: if (job_valid_i) begin
        gx_q <= gx; gy_q <= gy;
        rem_q <= sq; root_q <= '0; step_q <= 4'd10;
        row_q <= job_i.row; col_q <= job_i.col;
        ch_q <= job_i.ch; last_q <= job_i.last;
      end
      BeSqrt: begin
        if ({1'b0, rem_q} >= tsq) root_q <= trial;
        if (step_q != 4'd0) step_q <= step_q - 4'd1;
        ay_q  <= {10'd0, fy[9:0], 16'd0};
        lo_q  <= 36'(ax) * 36'(TanLowQ16);
        hi_q  <= 36'(ax) * 36'(TanHighQ16);
        neg_q <= fx[10];
        gy0_q <= (fy == 11'sd0);
        gx0_q <= (fx == 11'sd0);
      end
      BeDir: ;
      BeOut: if (!out_valid_q || res_ready_i) begin
        out_q.magnitude   <= root_q;
        out_q.direction   <= dir;
        out_q.out_row     <= row_q;
        out_q.out_column  <= col_q;
        out_q.out_channel <= ch_q;
        out_q.last_of_run <= last_q;
      end
      default: ;
    endcase
  end

  assign res_valid_o = out_valid_q;
  assign res_o = out_q;

endmodule

/* hdl/sobel_gradient_magnitude_direction_core.sv */
// Channel     | dir | payload
// in_if       | in  | sample[7:0]
// out_if      | out | magnitude, direction, out_row, out_column, out_channel, last_of_run
// cfg_*       | in  | cfg_idx_i[1:0], cfg_data_i[11:0], write on cfg_we_i
// Each sample passes the front end's line-store read and window update; its jobs are
// then issued before the next sample is taken. The back end takes one job at a time,
// running an 11-step root iteration for each. A 4-entry job queue decouples them.
// Reset clears counters, windows and handshake state; line stores are not cleared.
module sobel_gradient_magnitude_direction_core (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [sgm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sgm_pkg::CfgW-1:0]    cfg_data_i,
  sgm_stream_if.sink   in_if,
  sgm_stream_if.source out_if
);
  import sgm_pkg::*;

  sgm_job_t fj, qj;
  logic fv, fr, qv, qr;

  sgm_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_sample_i(in_if.data),
    .job_valid_o(fv), .job_ready_i(fr), .job_o(fj)
  );

  sgm_queue #(.Depth(4)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fj),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qj)
  );

  sgm_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(qv), .job_ready_o(qr), .job_i(qj),
    .res_valid_o(out_if.valid), .res_ready_i(out_if.ready), .res_o(out_if.data)
  );

`ifndef SYNTHESIS
  // A job is never dropped: while queue is full the front holds its job
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fv && !fr) |=> fv) else $error("front job dropped while queue full");
  // Input is stalled while the front end still has work
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fv |-> !in_if.ready) else $error("input taken while jobs pending");
`endif

endmodule
